// ----- rtl/utf8v_pkg.sv -----
// Shared types and constants for the UTF-8 stream validator.
`timescale 1ns / 1ps

package utf8v_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        point_ready;
    logic [2:0]  status;
    logic        buffer_done;
    logic        buffer_ok;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  bytes_still_needed;
    logic [1:0]  sequence_length;
    logic [20:0] partial_value;
    logic [2:0]  sticky_error;
  } dec_state_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD = 3'd1;
  localparam logic [2:0] ST_BAD_CONT = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] ASCII_LO   = 8'h01;
  localparam logic [7:0] ASCII_HI   = 8'h7f;
  localparam logic [7:0] LEAD2_LO   = 8'hc2;
  localparam logic [7:0] LEAD2_HI   = 8'hdf;
  localparam logic [7:0] LEAD3_LO   = 8'he0;
  localparam logic [7:0] LEAD3_HI   = 8'hef;
  localparam logic [7:0] LEAD4_LO   = 8'hf0;
  localparam logic [7:0] LEAD4_HI   = 8'hf4;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  localparam logic [20:0] MIN_THREE = 21'h000800;
  localparam logic [20:0] MIN_FOUR  = 21'h010000;
  localparam logic [20:0] SURR_LO   = 21'h00d800;
  localparam logic [20:0] SURR_HI   = 21'h00dfff;
  localparam logic [20:0] MAX_POINT = 21'h10ffff;

endpackage

// ----- rtl/utf8_stream_validator.sv -----
// Top level of the strict UTF-8 stream validator and decoder.
`timescale 1ns / 1ps

// The block takes one byte per cycle unless the output stalls, and returns one result
// word per byte; each byte passes through the input register and then the decode
// stage that updates the sequence state and loads the result register. Both stages
// advance together whenever the result register is empty or being read, so a full
// stream runs at one byte per clock; the only loop is the state update in the decode
// stage. The first error of a buffer is held and reported on every later byte, and the
// state returns to its reset value after the byte marked as the end of the buffer.
module utf8_stream_validator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utf8v_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf8v_pkg::out_word_t out_word
);
  import utf8v_pkg::*;

  logic       s_valid;
  logic       s_ready;
  in_word_t   s_word;
  dec_state_t state_r;
  dec_state_t state_nxt;
  out_word_t  res_word;
  out_word_t  out_word_r;
  logic       out_valid_r;
  logic       load;

  utf8v_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_word   (s_word)
  );

  utf8v_step u_step (
    .cur_word  (s_word),
    .cur_state (state_r),
    .nxt_state (state_nxt),
    .res_word  (res_word)
  );

  assign s_ready   = !out_valid_r || out_ready;
  assign load      = s_valid && s_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= res_word;
    end
  end

  a_point_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.point_ready |-> out_word.status == ST_OK)
    else $error("code point delivered with an error status");

  a_verdict : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.buffer_ok |-> out_word.buffer_done && out_word.status == ST_OK)
    else $error("buffer verdict inconsistent with status");

  a_scalar : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.point_ready |->
      out_word.code_point <= MAX_POINT &&
      (out_word.code_point < SURR_LO || out_word.code_point > SURR_HI))
    else $error("delivered code point is not a scalar value");

  a_clear : assert property (@(posedge clk) disable iff (!rst_n)
    load && s_word.end_of_buffer |=> state_r == '0)
    else $error("state not cleared after end of buffer");

  a_open_err : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.sticky_error != ST_OK |-> state_r.bytes_still_needed == 2'd0)
    else $error("sequence left open after an error");

endmodule

// ----- rtl/utf8v_in_reg.sv -----
// Input register stage that holds one word between the input port and the decoder.
`timescale 1ns / 1ps

module utf8v_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  utf8v_pkg::in_word_t in_word,
  output logic               s_valid,
  input  logic               s_ready,
  output utf8v_pkg::in_word_t s_word
);
  import utf8v_pkg::*;

  logic     valid_r;
  in_word_t word_r;

  assign in_ready = !valid_r || s_ready;
  assign s_valid  = valid_r;
  assign s_word   = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (s_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

// ----- rtl/utf8v_step.sv -----
// Combinational decode of one byte against the current sequence state.
`timescale 1ns / 1ps

module utf8v_step (
  input  utf8v_pkg::in_word_t  cur_word,
  input  utf8v_pkg::dec_state_t cur_state,
  output utf8v_pkg::dec_state_t nxt_state,
  output utf8v_pkg::out_word_t  res_word
);
  import utf8v_pkg::*;

  logic [7:0]  b;
  logic [20:0] v;
  logic        bad_range;
  dec_state_t  st;
  logic [20:0] cp;
  logic        rdy;

  assign b = cur_word.byte_in;
  assign v = {cur_state.partial_value[14:0], b[5:0]};

  assign bad_range = ((cur_state.sequence_length == 2'd2) && (v < MIN_THREE)) ||
                     ((cur_state.sequence_length == 2'd3) && (v < MIN_FOUR)) ||
                     ((v >= SURR_LO) && (v <= SURR_HI)) || (v > MAX_POINT);

  always_comb begin
    st  = cur_state;
    cp  = '0;
    rdy = 1'b0;
    if (cur_state.sticky_error == ST_OK) begin
      if (cur_state.bytes_still_needed == 2'd0) begin
        unique case (b) inside
          ZERO_BYTE: begin
            st.sticky_error = ST_ZERO;
          end
          [ASCII_LO:ASCII_HI]: begin
            cp  = {13'd0, b};
            rdy = 1'b1;
          end
          [LEAD2_LO:LEAD2_HI]: begin
            st.partial_value      = {16'd0, b[4:0]};
            st.bytes_still_needed = 2'd1;
            st.sequence_length    = 2'd1;
          end
          [LEAD3_LO:LEAD3_HI]: begin
            st.partial_value      = {17'd0, b[3:0]};
            st.bytes_still_needed = 2'd2;
            st.sequence_length    = 2'd2;
          end
          [LEAD4_LO:LEAD4_HI]: begin
            st.partial_value      = {18'd0, b[2:0]};
            st.bytes_still_needed = 2'd3;
            st.sequence_length    = 2'd3;
          end
          default: begin
            st.sticky_error = ST_BAD_LEAD;
          end
        endcase
      end else if (b[7:6] != CONT_TAG) begin
        st.sticky_error = ST_BAD_CONT;
      end else begin
        st.partial_value      = v;
        st.bytes_still_needed = cur_state.bytes_still_needed - 2'd1;
        if (cur_state.bytes_still_needed == 2'd1) begin
          if (bad_range) begin
            st.sticky_error = ST_RANGE;
          end else begin
            cp  = v;
            rdy = 1'b1;
          end
          st.sequence_length = 2'd0;
          st.partial_value   = '0;
        end
      end
      if (st.sticky_error != ST_OK) begin
        st.bytes_still_needed = 2'd0;
        st.sequence_length    = 2'd0;
        st.partial_value      = '0;
      end
    end

    if (cur_word.end_of_buffer && (st.sticky_error == ST_OK) &&
        (st.bytes_still_needed != 2'd0)) begin
      st.sticky_error = ST_TRUNC;
    end

    res_word.code_point  = cp;
    res_word.point_ready = rdy;
    res_word.status      = st.sticky_error;
    res_word.buffer_done = cur_word.end_of_buffer;
    res_word.buffer_ok   = cur_word.end_of_buffer && (st.sticky_error == ST_OK);

    nxt_state = cur_word.end_of_buffer ? '0 : st;
  end

endmodule

// ----- tb/sv/tb_utf8_stream_validator.sv -----
// Self-checking testbench for the strict UTF-8 stream validator and decoder.
`timescale 1ns / 1ps

module tb_utf8_stream_validator;
  import utf8v_pkg::*;

  localparam int HOLD_CYCLES = 64;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  utf8_stream_validator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  dec_state_t  dec_st;
  out_word_t   decoded_queue[$];
  logic [7:0]  buf_bytes[$];
  int          error_count = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  always #10 clk = ~clk;

  function automatic out_word_t decode_byte(in_word_t w);
    out_word_t   r;
    logic [20:0] acc;
    r = '0;
    if (dec_st.sticky_error == ST_OK) begin
      if (dec_st.bytes_still_needed == 2'd0) begin
        if (w.byte_in == ZERO_BYTE) begin
          dec_st.sticky_error = ST_ZERO;
        end else if (w.byte_in <= ASCII_HI) begin
          r.code_point  = {13'd0, w.byte_in};
          r.point_ready = 1'b1;
        end else if (w.byte_in >= LEAD2_LO && w.byte_in <= LEAD2_HI) begin
          dec_st.partial_value      = {16'd0, w.byte_in[4:0]};
          dec_st.bytes_still_needed = 2'd1;
          dec_st.sequence_length    = 2'd1;
        end else if (w.byte_in >= LEAD3_LO && w.byte_in <= LEAD3_HI) begin
          dec_st.partial_value      = {17'd0, w.byte_in[3:0]};
          dec_st.bytes_still_needed = 2'd2;
          dec_st.sequence_length    = 2'd2;
        end else if (w.byte_in >= LEAD4_LO && w.byte_in <= LEAD4_HI) begin
          dec_st.partial_value      = {18'd0, w.byte_in[2:0]};
          dec_st.bytes_still_needed = 2'd3;
          dec_st.sequence_length    = 2'd3;
        end else begin
          dec_st.sticky_error = ST_BAD_LEAD;
        end
      end else if (w.byte_in[7:6] != CONT_TAG) begin
        dec_st.sticky_error = ST_BAD_CONT;
      end else begin
        acc = {dec_st.partial_value[14:0], w.byte_in[5:0]};
        dec_st.partial_value      = acc;
        dec_st.bytes_still_needed = dec_st.bytes_still_needed - 2'd1;
        if (dec_st.bytes_still_needed == 2'd0) begin
          if ((dec_st.sequence_length == 2'd2 && acc < MIN_THREE) ||
              (dec_st.sequence_length == 2'd3 && acc < MIN_FOUR) ||
              (acc >= SURR_LO && acc <= SURR_HI) || acc > MAX_POINT) begin
            dec_st.sticky_error = ST_RANGE;
          end else begin
            r.code_point  = acc;
            r.point_ready = 1'b1;
          end
          dec_st.sequence_length = 2'd0;
          dec_st.partial_value   = '0;
        end
      end
      if (dec_st.sticky_error != ST_OK) begin
        dec_st.bytes_still_needed = 2'd0;
        dec_st.sequence_length    = 2'd0;
        dec_st.partial_value      = '0;
      end
    end
    if (w.end_of_buffer && dec_st.sticky_error == ST_OK && dec_st.bytes_still_needed != 2'd0) begin
      dec_st.sticky_error = ST_TRUNC;
    end
    r.status      = dec_st.sticky_error;
    r.buffer_done = w.end_of_buffer;
    if (w.end_of_buffer) begin
      r.buffer_ok = (dec_st.sticky_error == ST_OK);
      dec_st      = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [20:0] got,
                                 input logic [20:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(negedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_queue.size() == 0) begin
        report_mismatch("unexpected word, code_point", out_word.code_point, '0);
      end else begin
        want = decoded_queue.pop_front();
        if (out_word.code_point != want.code_point)
          report_mismatch("code_point", out_word.code_point, want.code_point);
        if (out_word.point_ready != want.point_ready)
          report_mismatch("point_ready", 21'(out_word.point_ready), 21'(want.point_ready));
        if (out_word.status != want.status)
          report_mismatch("status", 21'(out_word.status), 21'(want.status));
        if (out_word.buffer_done != want.buffer_done)
          report_mismatch("buffer_done", 21'(out_word.buffer_done), 21'(want.buffer_done));
        if (out_word.buffer_ok != want.buffer_ok)
          report_mismatch("buffer_ok", 21'(out_word.buffer_ok), 21'(want.buffer_ok));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_word_t w;
    logic     taken;
    w.byte_in       = b;
    w.end_of_buffer = last;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    decoded_queue.push_back(decode_byte(w));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (decoded_queue.size() != 0);
  endtask

  task automatic push_encoded(input logic [20:0] cp, input int n);
    case (n)
      1: buf_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        buf_bytes.push_back({3'b110, cp[10:6]});
        buf_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        buf_bytes.push_back({4'b1110, cp[15:12]});
        buf_bytes.push_back({2'b10, cp[11:6]});
        buf_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        buf_bytes.push_back({5'b11110, cp[20:18]});
        buf_bytes.push_back({2'b10, cp[17:12]});
        buf_bytes.push_back({2'b10, cp[11:6]});
        buf_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Most buffers are well formed; the rest may mix malformed sequences among valid ones.
  task automatic send_random_buffer(output int sent);
    int          elements;
    int          roll;
    int          n;
    bit          clean;
    logic [20:0] cp;
    logic [7:0]  b;
    buf_bytes.delete();
    clean    = ($urandom_range(99) < 60);
    elements = $urandom_range(8, 1);
    repeat (elements) begin
      roll = clean ? $urandom_range(64) : $urandom_range(99);
      if (roll < 25) begin
        push_encoded(21'($urandom_range(8'h7f, 8'h01)), 1);
      end else if (roll < 40) begin
        push_encoded(21'($urandom_range(12'h7ff, 12'h080)), 2);
      end else if (roll < 55) begin
        cp = 21'($urandom_range(16'hffff, 16'h0800));
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h002000;
        push_encoded(cp, 3);
      end else if (roll < 65) begin
        push_encoded(21'($urandom_range(21'h10ffff, 21'h010000)), 4);
      end else if (roll < 70) begin
        buf_bytes.push_back(8'($urandom_range(255)));
      end else if (roll < 74) begin
        n = $urandom_range(4, 2);
        push_encoded(21'($urandom_range(21'h10ffff, 21'h010000)), n);
        repeat ($urandom_range(n - 1, 1)) void'(buf_bytes.pop_back());
      end else if (roll < 78) begin
        n = $urandom_range(4, 2);
        if (n == 2) push_encoded(21'($urandom_range(8'h7f)), 2);
        else if (n == 3) push_encoded(21'($urandom_range(12'h7ff)), 3);
        else push_encoded(21'($urandom_range(16'hffff)), 4);
      end else if (roll < 82) begin
        push_encoded(21'($urandom_range(SURR_HI, SURR_LO)), 3);
      end else if (roll < 86) begin
        push_encoded(21'($urandom_range(21'h1fffff, 21'h110000)), 4);
      end else if (roll < 89) begin
        buf_bytes.push_back(ZERO_BYTE);
      end else if (roll < 94) begin
        buf_bytes.push_back(8'($urandom_range(LEAD4_HI, LEAD2_LO)));
        b = 8'($urandom_range(255));
        if (b[7:6] == CONT_TAG) b[6] = 1'b1;
        buf_bytes.push_back(b);
      end else begin
        buf_bytes.push_back({CONT_TAG, 6'($urandom_range(63))});
      end
    end
    foreach (buf_bytes[i]) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
    sent = buf_bytes.size();
  endtask

  task automatic run_random(input int n_words, input int idle_pct, input int stall_pct);
    int total;
    int sent;
    total         = 0;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    while (total < n_words) begin
      send_random_buffer(sent);
      total += sent;
    end
  endtask

  task automatic test_directed();
    logic [8:0] script[$];
    script = '{
      {1'b1, 8'h7f},
      {1'b0, 8'h01}, {1'b0, 8'hc2}, {1'b0, 8'h80}, {1'b0, 8'hdf}, {1'b1, 8'hbf},
      {1'b0, 8'hf4}, {1'b0, 8'h8f}, {1'b0, 8'hbf}, {1'b1, 8'hbf},
      {1'b0, 8'hff}, {1'b1, 8'h00},
      {1'b0, 8'he0}, {1'b0, 8'h80}, {1'b1, 8'h80},
      {1'b0, 8'hc2}, {1'b1, 8'h41},
      {1'b0, 8'hed}, {1'b0, 8'ha0}, {1'b1, 8'h80},
      {1'b0, 8'hf0}, {1'b1, 8'h90},
      {1'b1, 8'h00},
      {1'b0, 8'hf4}, {1'b0, 8'h90}, {1'b0, 8'h80}, {1'b1, 8'h80}
    };
    in_idle_pct   = 0;
    out_stall_pct = 0;
    foreach (script[i]) send_byte(script[i][7:0], script[i][8]);
  endtask

  task automatic test_streaming();
    run_random(470, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random(470, 48, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random(470, 0, 48);
  endtask

  task automatic test_mixed_idling();
    run_random(470, 19, 19);
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    wait_drained();
    @(negedge clk);
    hold_req = hold_req + 1;
    @(posedge clk);
    run_random(40, 0, 0);
    wait_drained();
    run_random(20, 0, 0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    dec_st    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_backpressure();
    out_stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_utf8_stream_validator: clean");
    end else begin
      $display("tb_utf8_stream_validator: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_utf8_stream_validator: errors");
    $finish;
  end

endmodule
